// ----- rtl/core/preemptive_priority_scheduler_unit_macros.svh -----
// assertion macros for the priority scheduler
// expects clk and arst_n in the scope of each use
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

`define PPSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define PPSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ppsu_pkg.sv -----
// types and constants for the priority scheduler
// no dependencies
`default_nettype none

package ppsu_pkg;

	localparam int MAX_JOBS_DEF = 16;

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] ST_ADDED = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RAN   = 2'd2;
	localparam logic [1:0] ST_IDLE  = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [15:0] arrival_time;
		logic [15:0] burst_length;
		logic [7:0]  priority_level;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  job_number;
		logic [31:0] time_now;
		logic        finished;
		logic [31:0] completion_time;
		logic [31:0] turnaround_time;
		logic [31:0] waiting_time;
		logic [31:0] response_time;
		logic        all_done;
	} res_t;

	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  prio;
		logic [31:0] first_run;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppsu_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ppsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/preemptive_priority_scheduler_unit.sv -----
// priority scheduler: an add strobes done in the cycle after its accepting edge
// tick: the scan does one ram read per entry, then an update; a finishing job then passes
// S_TAT, S_WT and S_RT, which share one 32-bit subtractor for the finish times
// busy until the done cycle, which can take the next word; results cannot be stalled
// arst_n clears the counters and time; table contents are undefined until added
// depends on ppsu_pkg, ppsu_ram and the macros header
`default_nettype none

`include "preemptive_priority_scheduler_unit_macros.svh"

module preemptive_priority_scheduler_unit #(
	parameter int MAX_JOBS = ppsu_pkg::MAX_JOBS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ppsu_pkg::req_t request,
	output logic                busy,
	output logic                done,
	output ppsu_pkg::res_t      result
);
	import ppsu_pkg::*;

	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam int EW = $bits(entry_t);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_JOBS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_TAT,
		S_WT,
		S_RT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   left_q;
	logic [31:0]     time_q;
	logic [CW-1:0]   iss_q;
	logic            cmp_vld_q;
	logic [IW-1:0]   cmp_idx_q;
	logic            found_q;
	logic [IW-1:0]   best_idx_q;
	entry_t          best_q;
	logic [31:0]     turn_q;
	logic [31:0]     wait_q;
	logic            done_q;
	res_t            res_q;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic [EW-1:0]   ram_rdata;
	entry_t          rd_ent;

	logic [31:0]     time_next;
	logic [31:0]     sub_a;
	logic [31:0]     sub_b;
	logic [32:0]     sub_res;
	logic            better;
	entry_t          upd_ent;
	logic [CW-1:0]   cnt_inc;
	logic [CW-1:0]   left_add;
	logic [CW-1:0]   left_dec;
	logic [4:0]      best_num;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;
	assign rd_ent = entry_t'(ram_rdata);

	ppsu_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_JOBS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(iss_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign time_next = (time_q == TIME_MAX) ? time_q : time_q + 32'd1;
	assign cnt_inc   = count_q + CW'(1);
	assign left_add  = (request.burst_length != 16'd0) ? left_q + CW'(1) : left_q;
	assign left_dec  = (left_q != '0) ? left_q - CW'(1) : left_q;
	assign best_num  = 5'(CW'(best_idx_q) + CW'(1));

	assign better = ({16'd0, rd_ent.arrival} <= time_q) && (rd_ent.remaining != 16'd0)
		&& (!found_q || (rd_ent.prio < best_q.prio));

	// shared subtractor for the finish times
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		case (state_q)
			S_TAT: begin
				sub_a = time_q;
				sub_b = {16'd0, best_q.arrival};
			end
			S_WT: begin
				sub_a = turn_q;
				sub_b = {16'd0, best_q.burst};
			end
			S_RT: begin
				sub_a = best_q.first_run;
				sub_b = {16'd0, best_q.arrival};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
		sub_res = {1'b0, sub_a} - {1'b0, sub_b};
	end

	always_comb begin
		upd_ent           = best_q;
		upd_ent.remaining = best_q.remaining - 16'd1;
		if (best_q.remaining == best_q.burst) begin
			upd_ent.first_run = time_q;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = upd_ent;
		if (state_q == S_IDLE) begin
			ram_waddr = count_q[IW-1:0];
			ram_wdata = '{arrival: request.arrival_time, burst: request.burst_length,
				remaining: request.burst_length, prio: request.priority_level,
				first_run: 32'd0};
			ram_we = start && (request.cmd == CMD_ADD) && (count_q != FULL_COUNT);
		end else if (state_q == S_UPDATE) begin
			ram_we = found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			left_q    <= '0;
			time_q    <= '0;
			iss_q     <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (request.cmd == CMD_ADD) begin
							res_q          <= '0;
							res_q.time_now <= time_q;
							done_q         <= 1'b1;
							if (count_q == FULL_COUNT) begin
								res_q.status   <= ST_FULL;
								res_q.all_done <= (left_q == '0);
							end else begin
								res_q.status     <= ST_ADDED;
								res_q.job_number <= 5'(cnt_inc);
								res_q.all_done   <= (left_add == '0);
								count_q          <= cnt_inc;
								left_q           <= left_add;
							end
						end else begin
							iss_q     <= '0;
							cmp_vld_q <= 1'b0;
							found_q   <= 1'b0;
							state_q   <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (iss_q != count_q) begin
						iss_q     <= iss_q + CW'(1);
						cmp_vld_q <= 1'b1;
					end else begin
						cmp_vld_q <= 1'b0;
					end
					if (cmp_vld_q && better) begin
						found_q <= 1'b1;
					end
					if (iss_q == count_q && !cmp_vld_q) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					time_q         <= time_next;
					res_q          <= '0;
					res_q.time_now <= time_next;
					res_q.all_done <= (left_q == '0);
					if (!found_q) begin
						res_q.status <= ST_IDLE;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else if (upd_ent.remaining != 16'd0) begin
						res_q.status     <= ST_RAN;
						res_q.job_number <= best_num;
						done_q           <= 1'b1;
						state_q          <= S_IDLE;
					end else begin
						state_q <= S_TAT;
					end
				end
				S_TAT: begin
					state_q <= S_WT;
				end
				S_WT: begin
					state_q <= S_RT;
				end
				S_RT: begin
					res_q.status          <= ST_RAN;
					res_q.job_number      <= best_num;
					res_q.time_now        <= time_q;
					res_q.finished        <= 1'b1;
					res_q.completion_time <= time_q;
					res_q.turnaround_time <= turn_q;
					res_q.waiting_time    <= wait_q;
					res_q.response_time   <= sub_res[31:0];
					res_q.all_done        <= (left_dec == '0);
					left_q                <= left_dec;
					done_q                <= 1'b1;
					state_q               <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath words, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_SCAN: begin
				cmp_idx_q <= iss_q[IW-1:0];
				if (cmp_vld_q && better) begin
					best_idx_q <= cmp_idx_q;
					best_q     <= rd_ent;
				end
			end
			S_UPDATE: begin
				best_q <= upd_ent;
			end
			S_TAT: begin
				turn_q <= sub_res[31:0];
			end
			S_WT: begin
				wait_q <= sub_res[32] ? 32'd0 : sub_res[31:0];
			end
			default: begin
				cmp_idx_q <= cmp_idx_q;
			end
		endcase
	end

	`PPSU_ASSERT_NEXT(a_add_one_cycle, start && !busy && request.cmd == CMD_ADD, done && !busy, "add word not answered next cycle")
	`PPSU_ASSERT_NEXT(a_tick_busy, start && !busy && request.cmd == CMD_TICK, busy && !done, "tick word did not start a scan")
	`PPSU_ASSERT_NOW(a_scan_bound, state_q == S_SCAN, iss_q <= count_q, "scan ran past the table")
	`PPSU_ASSERT_NOW(a_finish_ran, done && result.finished, result.status == ST_RAN, "finish without a run")
	`PPSU_ASSERT_NOW(a_full_drop, done && result.status == ST_FULL, count_q == FULL_COUNT, "drop with room left")

endmodule

`default_nettype wire

// ----- tb/sv/preemptive_priority_scheduler_unit_tb.sv -----
// self-checking testbench for the preemptive priority scheduler unit
// keeps its own copy of the job table and predicts every result word
// depends on ppsu_pkg and preemptive_priority_scheduler_unit
`default_nettype none

module preemptive_priority_scheduler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppsu_pkg::*;

	localparam int TABLE_DEPTH  = MAX_JOBS_DEF;
	localparam int NO_PRIO      = 9999;
	localparam int RANDOM_WORDS = 1200;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic start;
	req_t request;
	logic busy;
	logic done;
	res_t result;

	preemptive_priority_scheduler_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	// predicted job table
	logic [15:0] tab_arrival   [TABLE_DEPTH];
	logic [15:0] tab_burst     [TABLE_DEPTH];
	logic [15:0] tab_left      [TABLE_DEPTH];
	logic [7:0]  tab_prio      [TABLE_DEPTH];
	logic [31:0] tab_first_run [TABLE_DEPTH];
	int unsigned tab_count;
	int unsigned jobs_open;
	logic [31:0] clock_now;

	res_t outcome_q[$];
	res_t due_word;
	int   mismatches;
	int   stall_cycles;
	int   calm_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t schedule_step(input req_t w);
		res_t        r;
		int unsigned best;
		int unsigned best_prio;
		bit          found;
		logic [31:0] turn;
		int unsigned i;
		r = '0;
		if (w.cmd == CMD_ADD) begin
			if (tab_count >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				tab_arrival[tab_count]   = w.arrival_time;
				tab_burst[tab_count]     = w.burst_length;
				tab_left[tab_count]      = w.burst_length;
				tab_prio[tab_count]      = w.priority_level;
				tab_first_run[tab_count] = '0;
				tab_count++;
				if (w.burst_length != 0)
					jobs_open++;
				r.status     = ST_ADDED;
				r.job_number = tab_count[4:0];
			end
		end else begin
			best      = 0;
			best_prio = NO_PRIO;
			found     = 1'b0;
			for (i = 0; i < tab_count; i++) begin
				if (tab_arrival[i] <= clock_now && tab_left[i] != 0 &&
						tab_prio[i] < best_prio) begin
					best      = i;
					best_prio = tab_prio[i];
					found     = 1'b1;
				end
			end
			if (!found) begin
				clock_now = (clock_now == TIME_MAX) ? clock_now : clock_now + 1;
				r.status  = ST_IDLE;
			end else begin
				if (tab_left[best] == tab_burst[best])
					tab_first_run[best] = clock_now;
				tab_left[best]--;
				clock_now    = (clock_now == TIME_MAX) ? clock_now : clock_now + 1;
				r.status     = ST_RAN;
				r.job_number = 5'(best + 1);
				if (tab_left[best] == 0) begin
					turn              = clock_now - tab_arrival[best];
					r.finished        = 1'b1;
					r.completion_time = clock_now;
					r.turnaround_time = turn;
					r.waiting_time    = (turn >= tab_burst[best]) ? turn - tab_burst[best] : '0;
					r.response_time   = tab_first_run[best] - tab_arrival[best];
					if (jobs_open > 0)
						jobs_open--;
				end
			end
		end
		r.time_now = clock_now;
		r.all_done = (jobs_open == 0);
		return r;
	endfunction

	function automatic req_t make_add(input logic [15:0] arr, input logic [15:0] burst,
			input logic [7:0] prio);
		req_t w;
		w.cmd            = CMD_ADD;
		w.arrival_time   = arr;
		w.burst_length   = burst;
		w.priority_level = prio;
		return w;
	endfunction

	function automatic req_t make_tick();
		req_t w;
		w.cmd            = CMD_TICK;
		w.arrival_time   = 16'($urandom);
		w.burst_length   = 16'($urandom);
		w.priority_level = 8'($urandom);
		return w;
	endfunction

	function automatic req_t random_add();
		logic [15:0] arr;
		logic [15:0] burst;
		logic [7:0]  prio;
		if ($urandom_range(0, 3) == 0)
			arr = 16'($urandom_range(0, clock_now));
		else
			arr = 16'(clock_now + $urandom_range(0, 30));
		burst = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 100));
		prio  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
		return make_add(arr, burst, prio);
	endfunction

	// start stays high across back-to-back words
	task automatic send_word(input req_t w);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 9);
			if ($urandom_range(0, 49) == 0)
				calm_left = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= w;
		do @(posedge clk); while (busy);
		outcome_q.push_back(schedule_step(w));
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] e, input logic [31:0] a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0h, got %0h at %0t", what, e, a, $realtime);
	endtask

	task automatic check_field(input string what, input logic [31:0] e, input logic [31:0] a);
		if (e !== a)
			note_mismatch(what, e, a);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				note_mismatch("unexpected word", '0, '0);
			end else begin
				due_word = outcome_q.pop_front();
				check_field("status", due_word.status, result.status);
				check_field("job_number", due_word.job_number, result.job_number);
				check_field("time_now", due_word.time_now, result.time_now);
				check_field("finished", due_word.finished, result.finished);
				check_field("completion_time", due_word.completion_time, result.completion_time);
				check_field("turnaround_time", due_word.turnaround_time, result.turnaround_time);
				check_field("waiting_time", due_word.waiting_time, result.waiting_time);
				check_field("response_time", due_word.response_time, result.response_time);
				check_field("all_done", due_word.all_done, result.all_done);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// empty table, tie on priority, zero burst, preemption, late arrival
	task automatic test_basic_schedule();
		int n;
		send_word(make_tick());
		send_word(make_add(16'd0, 16'd4, 8'd5));
		send_word(make_add(16'd0, 16'd1, 8'd5));
		send_word(make_add(16'd0, 16'd0, 8'd0));
		send_word(make_add(16'd3, 16'd1, 8'd0));
		for (n = 0; n < 7; n++)
			send_word(make_tick());
		send_word(make_add(16'd0, 16'd1, 8'd255));
		send_word(make_tick());
		send_word(make_tick());
	endtask

	task automatic test_random_schedule();
		int n;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (tab_count < TABLE_DEPTH - 1 && $urandom_range(0, 79) == 0)
				send_word(random_add());
			else
				send_word(make_tick());
		end
	endtask

	// last slot gets the largest fields, then adds are dropped
	task automatic test_full_table();
		int n;
		while (tab_count < TABLE_DEPTH - 1)
			send_word(random_add());
		send_word(make_add(16'hFFFF, 16'hFFFF, 8'hFF));
		send_word(make_add(16'hFFFF, 16'hFFFF, 8'hFF));
		for (n = 0; n < 36; n++) begin
			if ($urandom_range(0, 1))
				send_word(make_add(16'($urandom), 16'($urandom), 8'($urandom)));
			else
				send_word(make_tick());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		request      = '0;
		tab_count    = 0;
		jobs_open    = 0;
		clock_now    = '0;
		mismatches   = 0;
		stall_cycles = 0;
		calm_left    = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_schedule();
		test_random_schedule();
		test_full_table();
		start <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outcome_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
